// ===== sv/ilst_pkg.sv =====
// Shared types and constants for the indexed list store.
`default_nettype none
package ilst_pkg;

   // Operation codes carried in the func field.
   localparam logic [2:0] FUNC_GET      = 3'd0;
   localparam logic [2:0] FUNC_ADD_HEAD = 3'd1;
   localparam logic [2:0] FUNC_ADD_TAIL = 3'd2;
   localparam logic [2:0] FUNC_ADD_IDX  = 3'd3;
   localparam logic [2:0] FUNC_DELETE   = 3'd4;

   // Result status codes.
   localparam logic [1:0] STATUS_DONE   = 2'd0;
   localparam logic [1:0] STATUS_BADPOS = 2'd1;
   localparam logic [1:0] STATUS_FULL   = 2'd2;

   // Field widths.
   localparam int FUNC_W  = 3;
   localparam int POS_W   = 8;
   localparam int VALUE_W = 32;
   localparam int STAT_W  = 2;
   localparam int FILL_W  = 7;

   // Packed channel widths, padded to whole bytes.
   localparam int REQ_W = 48;
   localparam int RSP_W = 48;

   localparam logic [VALUE_W-1:0] NOT_FOUND = '1;

endpackage
`default_nettype wire

// ===== sv/ilst_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module ilst_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire                       clock,
   input  wire                       wr_en,
   input  wire  [$clog2(DEPTH)-1:0]  wr_addr,
   input  wire  [WIDTH-1:0]          wr_data,
   input  wire  [$clog2(DEPTH)-1:0]  rd_addr,
   output logic [WIDTH-1:0]          rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule
`default_nettype wire

// ===== sv/indexed_list_store.sv =====
// Indexed list store: ordered list of signed 32-bit values held in one RAM.
// Path to rsp_tvalid: get via GET_WAIT; insert via SHIFT_UP per moved entry, then PLACE (append
//   written in IDLE); delete via SHIFT_DN per moved entry; all end in FINISH, rejected items go
//   there directly. One RAM read and write per moved entry. Throughput: one item at a time, next
//   item taken the cycle after the result registers. A stalled result holds FINISH and so the input.
// Reset: synchronous, active high; clears fill count, state and result valid, not the RAM.
`default_nettype none
module indexed_list_store #(
   parameter int CAPACITY = 64
) (
   input  wire                        clock,
   input  wire                        reset,
   // Request item
   input  wire                        req_tvalid,
   output logic                       req_tready,
   // [2:0] func, [10:3] position, [42:11] item_value, [47:43] zero
   input  wire  [ilst_pkg::REQ_W-1:0] req_tdata,
   // Result item
   output logic                       rsp_tvalid,
   input  wire                        rsp_tready,
   // [31:0] read_value, [33:32] status, [40:34] fill_count, [47:41] zero
   output logic [ilst_pkg::RSP_W-1:0] rsp_tdata
);
   import ilst_pkg::*;

   localparam int AW    = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int XW    = CNT_W + 8;          // room for position and count compares

   typedef enum logic [2:0] {
      IDLE, SHIFT_UP, PLACE, SHIFT_DN, GET_WAIT, FINISH
   } state_type;

   // request fields
   logic [FUNC_W-1:0]  req_func;
   logic [POS_W-1:0]   req_position;
   logic [VALUE_W-1:0] req_item_value;
   assign req_func       = req_tdata[FUNC_W-1:0];
   assign req_position   = req_tdata[FUNC_W +: POS_W];
   assign req_item_value = req_tdata[FUNC_W+POS_W +: VALUE_W];

   // registers
   state_type          state_ff,  state_in;
   logic [CNT_W-1:0]   count_ff,  count_in;
   logic [AW-1:0]      rd_ptr_ff;             // address read in the previous cycle
   logic [AW-1:0]      stop_ff,   stop_in;    // last address of the shift
   logic [VALUE_W-1:0] value_ff,  value_in;
   logic [VALUE_W-1:0] res_value_ff, res_value_in;
   logic [STAT_W-1:0]  res_stat_ff,  res_stat_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]   rsp_data_ff,  rsp_data_in;

   // RAM port
   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   logic [VALUE_W-1:0] wr_data;
   logic [AW-1:0]      rd_addr;
   logic [VALUE_W-1:0] rd_data;

   ilst_ram #(.WIDTH(VALUE_W), .DEPTH(CAPACITY)) u_entries (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // position and count checks
   logic              req_accept;
   logic              pos_neg;
   logic [XW-1:0]     pos_x, cnt_x, where_x;
   logic              pos_in_range, pos_le_count, is_full;
   logic [CNT_W-1:0]  cnt_m1;
   logic [CNT_W+6:0]  cnt_wide;
   logic [FILL_W-1:0] fill;

   assign req_accept   = req_tvalid && req_tready;
   assign pos_neg      = req_position[POS_W-1];
   assign pos_x        = {{(XW-POS_W+1){1'b0}}, req_position[POS_W-2:0]};
   assign cnt_x        = {8'b0, count_ff};
   assign pos_in_range = !pos_neg && (pos_x < cnt_x);
   assign pos_le_count = !pos_neg && (pos_x <= cnt_x);
   assign is_full      = (count_ff == CNT_W'(CAPACITY));
   assign cnt_m1       = count_ff - 1'b1;
   assign cnt_wide     = {7'b0, count_ff};
   assign fill         = cnt_wide[FILL_W-1:0];   // masked to the field width

   // insert point: head, tail, or the given position (bad position checked apart)
   always_comb begin
      priority if (req_func == FUNC_ADD_TAIL) begin
         where_x = cnt_x;
      end else if (req_func == FUNC_ADD_IDX && !pos_neg) begin
         where_x = pos_x;
      end else begin
         where_x = '0;
      end
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      stop_in      = stop_ff;
      value_in     = value_ff;
      res_value_in = res_value_ff;
      res_stat_in  = res_stat_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      wr_en        = 1'b0;
      wr_addr      = '0;
      wr_data      = rd_data;
      rd_addr      = rd_ptr_ff;

      unique case (state_ff)
         IDLE: begin
            // read issued speculatively; only used by the chosen path
            unique case (req_func)
               FUNC_GET:    rd_addr = pos_x[AW-1:0];
               FUNC_DELETE: rd_addr = pos_x[AW-1:0] + 1'b1;
               default:     rd_addr = cnt_m1[AW-1:0];
            endcase
            if (req_accept) begin
               res_value_in = NOT_FOUND;
               res_stat_in  = STATUS_BADPOS;
               value_in     = req_item_value;
               state_in     = FINISH;
               unique case (req_func)
                  FUNC_GET: begin
                     if (pos_in_range) begin
                        res_stat_in = STATUS_DONE;
                        state_in    = GET_WAIT;
                     end
                  end
                  FUNC_ADD_HEAD, FUNC_ADD_TAIL, FUNC_ADD_IDX: begin
                     if (req_func == FUNC_ADD_IDX && !pos_neg && !pos_le_count) begin
                        res_stat_in = STATUS_BADPOS;
                     end else if (is_full) begin
                        res_stat_in = STATUS_FULL;
                     end else begin
                        res_stat_in = STATUS_DONE;
                        count_in    = count_ff + 1'b1;
                        stop_in     = where_x[AW-1:0];
                        if (where_x == cnt_x) begin
                           // append: nothing to move
                           wr_en   = 1'b1;
                           wr_addr = where_x[AW-1:0];
                           wr_data = req_item_value;
                        end else begin
                           state_in = SHIFT_UP;
                        end
                     end
                  end
                  FUNC_DELETE: begin
                     if (pos_in_range) begin
                        res_stat_in = STATUS_DONE;
                        count_in    = cnt_m1;
                        stop_in     = cnt_m1[AW-1:0];
                        if (pos_x[AW-1:0] != cnt_m1[AW-1:0]) begin
                           state_in = SHIFT_DN;
                        end
                     end
                  end
                  default: ;
               endcase
            end
         end
         SHIFT_UP: begin
            // move entry rd_ptr up by one, walking towards the insert point
            wr_en   = 1'b1;
            wr_addr = rd_ptr_ff + 1'b1;
            rd_addr = rd_ptr_ff - 1'b1;
            if (rd_ptr_ff == stop_ff) begin
               state_in = PLACE;
            end
         end
         PLACE: begin
            wr_en    = 1'b1;
            wr_addr  = stop_ff;
            wr_data  = value_ff;
            state_in = FINISH;
         end
         SHIFT_DN: begin
            // close the gap: entry rd_ptr moves down by one
            wr_en   = 1'b1;
            wr_addr = rd_ptr_ff - 1'b1;
            rd_addr = rd_ptr_ff + 1'b1;
            if (rd_ptr_ff == stop_ff) begin
               state_in = FINISH;
            end
         end
         GET_WAIT: begin
            res_value_in = rd_data;
            state_in     = FINISH;
         end
         FINISH: begin
            // output register free or being emptied this cycle
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {{(RSP_W-VALUE_W-STAT_W-FILL_W){1'b0}},
                               fill, res_stat_ff, res_value_ff};
               state_in     = IDLE;
            end
         end
         default: state_in = IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rd_ptr_ff    <= rd_addr;
      stop_ff      <= stop_in;
      value_ff     <= value_in;
      res_value_ff <= res_value_in;
      res_stat_ff  <= res_stat_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign req_tready = (state_ff == IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
`default_nettype wire

// ===== sv/ilst_check.sv =====
// Port-level checks for the indexed list store, bound to the top level.
`default_nettype none
module ilst_check #(
   parameter int CAPACITY = 64
) (
   input wire                        clock,
   input wire                        reset,
   input wire                        req_tvalid,
   input wire                        req_tready,
   input wire                        rsp_tvalid,
   input wire                        rsp_tready,
   input wire [ilst_pkg::RSP_W-1:0]  rsp_tdata
);
   import ilst_pkg::*;

   logic [VALUE_W-1:0] rsp_value;
   logic [STAT_W-1:0]  rsp_stat;
   logic [FILL_W-1:0]  rsp_fill;
   logic [FILL_W-1:0]  cap_fill;
   logic               req_seen;

   assign rsp_value = rsp_tdata[VALUE_W-1:0];
   assign rsp_stat  = rsp_tdata[VALUE_W +: STAT_W];
   assign rsp_fill  = rsp_tdata[VALUE_W+STAT_W +: FILL_W];
   assign cap_fill  = FILL_W'(CAPACITY);
   assign req_seen  = req_tvalid && req_tready;

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // anything but a done status carries the not-found value
   a_fail_value: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_stat != STATUS_DONE |-> rsp_value == NOT_FOUND)
      else $error("failed item without not-found value");

   // a dropped insert only happens with the store full
   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_stat == STATUS_FULL |-> rsp_fill == cap_fill)
      else $error("full status with store not full");

   a_stat_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_stat == STATUS_DONE || rsp_stat == STATUS_BADPOS
                     || rsp_stat == STATUS_FULL)
      else $error("unknown status code");

   // no item is taken in the cycle straight after another
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_seen |=> !req_tready)
      else $error("request taken while busy");

endmodule

bind indexed_list_store ilst_check #(.CAPACITY(CAPACITY)) u_ilst_check (.*);
`default_nettype wire
